### hdl/ate_pkg.sv
// shared types and constants for the array table engine
package ate_pkg;

    // fixed field widths
    localparam int ACT_W  = 3;
    localparam int DATA_W = 32;
    localparam int POS_W  = 6;
    localparam int STAT_W = 2;
    localparam int FIDX_W = 6;
    localparam int FILL_W = 7;

    // first-match scan looks at this many cells per cycle
    localparam int SCAN_LG = 3;
    localparam int SCAN_W  = 1 << SCAN_LG;

    // command codes
    localparam logic [ACT_W-1:0] ACT_APPEND  = 3'd0;
    localparam logic [ACT_W-1:0] ACT_REMOVE  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_CLEAR   = 3'd2;
    localparam logic [ACT_W-1:0] ACT_FIND    = 3'd3;
    localparam logic [ACT_W-1:0] ACT_BSEARCH = 3'd4;
    localparam logic [ACT_W-1:0] ACT_REVERSE = 3'd5;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

    // what each cell does with its word in a cycle
    typedef enum logic [1:0] {
        CM_HOLD,
        CM_LOAD,
        CM_SHIFT,
        CM_SWAP
    } t_cell_mode;

    // command broadcast along the cell row
    typedef struct packed {
        t_cell_mode               mode;
        logic                     parity;
        logic signed [DATA_W-1:0] key;
    } t_cell_cmd;

endpackage

### hdl/ate_if.sv
// command and result channel interfaces of the array table engine
interface ate_cmd_if;
    logic                                     valid;
    logic                                     ready;
    logic        [ate_pkg::ACT_W-1:0]         action;
    logic signed [ate_pkg::DATA_W-1:0]        value;
    logic        [ate_pkg::POS_W-1:0]         position;

    modport source (output valid, action, value, position, input ready);
    modport sink   (input valid, action, value, position, output ready);
endinterface

interface ate_res_if;
    logic                          valid;
    logic                          ready;
    logic [ate_pkg::STAT_W-1:0]    status;
    logic                          found;
    logic [ate_pkg::FIDX_W-1:0]    found_index;
    logic [ate_pkg::FILL_W-1:0]    fill_count;

    modport source (output valid, status, found, found_index, fill_count, input ready);
    modport sink   (input valid, status, found, found_index, fill_count, output ready);
endinterface

### hdl/ate_cell.sv
// one storage cell of the row: holds a word, trades with its neighbors, compares to the key
module ate_cell #(
    parameter int IDX = 0,
    parameter int CW  = 7
) (
    input  logic                              i_clk,
    input  ate_pkg::t_cell_cmd                i_cmd,
    input  logic        [CW-1:0]              i_pos,
    input  logic signed [ate_pkg::DATA_W-1:0] i_prev,
    input  logic signed [ate_pkg::DATA_W-1:0] i_next,
    output logic signed [ate_pkg::DATA_W-1:0] o_data,
    output logic                              o_eq,
    output logic                              o_lt
);

    localparam logic [CW-1:0] IDX_C    = CW'(IDX);
    localparam logic [CW-1:0] IDX_N    = CW'(IDX + 1);
    localparam logic          IDX_ODD  = 1'(IDX % 2);
    localparam logic          HAS_PREV = (IDX > 0);

    logic signed [ate_pkg::DATA_W-1:0] r_data;
    logic signed [ate_pkg::DATA_W-1:0] n_data;
    logic                              r_eq;
    logic                              r_lt;

    // word update
    always_comb begin
        n_data = r_data;
        case (i_cmd.mode)
            ate_pkg::CM_LOAD: begin
                if (i_pos == IDX_C) n_data = i_cmd.key;
            end
            ate_pkg::CM_SHIFT: begin
                if (IDX_C >= i_pos) n_data = i_next;
            end
            ate_pkg::CM_SWAP: begin
                // left member of a pair takes the right word and vice versa
                if (IDX_ODD == i_cmd.parity) begin
                    if (IDX_N < i_pos) n_data = i_next;
                end else if (HAS_PREV && (IDX_C < i_pos)) begin
                    n_data = i_prev;
                end
            end
            default: n_data = r_data;
        endcase
    end

    // storage and registered compare against the key
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        r_eq   <= (r_data == i_cmd.key);
        r_lt   <= (i_cmd.key < r_data);
    end

    assign o_data = r_data;
    assign o_eq   = r_eq;
    assign o_lt   = r_lt;

endmodule

### hdl/array_table_engine.sv
// top level of the array table engine: cell row, sequencer and result register
//
//  channel  dir  payload                                    handshake
//  i_cmd    in   action, value, position                    valid/ready
//  o_res    out  status, found, found_index, fill_count     valid/ready
//
// append, remove, clear, unused codes and searches on an empty store go straight to S_OUT
// find stops at the first match: the match scan looks at 8 cells per cycle
// binary search: one probe per cycle until a hit or an empty range
// reverse of more than one word: one odd/even swap round per cycle
// reset clears the fill count, the sequencer and the result valid; the words are not cleared
// one item is in work at a time; a new item is taken while a result waits at o_res,
// and its result load then stalls until the waiting result is taken
module array_table_engine #(
    parameter int DEPTH = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ate_cmd_if.sink      i_cmd,
    ate_res_if.source    o_res
);

    localparam int CW     = $clog2(DEPTH + 1);
    localparam int IW     = $clog2(DEPTH);
    localparam int NCH    = (DEPTH + ate_pkg::SCAN_W - 1) / ate_pkg::SCAN_W;
    localparam int CHW    = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int PADW   = NCH * ate_pkg::SCAN_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FIND  = 3'd1;
    localparam logic [2:0] S_BSRCH = 3'd2;
    localparam logic [2:0] S_REV   = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    // control state
    logic [2:0]                        r_state, n_state;
    logic [CW-1:0]                     r_count, n_count;
    logic                              r_ovalid, n_ovalid;

    // work registers
    logic signed [ate_pkg::DATA_W-1:0] r_key, n_key;
    logic [CHW-1:0]                    r_chunk, n_chunk;
    logic [CW-1:0]                     r_lo, n_lo;
    logic [CW-1:0]                     r_hp, n_hp;
    logic [CW-1:0]                     r_round, n_round;
    logic [ate_pkg::STAT_W-1:0]        r_rstat, n_rstat;
    logic                              r_rfound, n_rfound;
    logic [ate_pkg::FIDX_W-1:0]        r_ridx, n_ridx;

    // result register
    logic [ate_pkg::STAT_W-1:0]        r_ostat;
    logic                              r_ofound;
    logic [ate_pkg::FIDX_W-1:0]        r_oidx;
    logic [ate_pkg::FILL_W-1:0]        r_ofill;

    // cell row
    ate_pkg::t_cell_cmd                w_ccmd;
    logic [CW-1:0]                     w_pos;
    logic signed [ate_pkg::DATA_W-1:0] w_data [DEPTH];
    logic [DEPTH-1:0]                  w_eq;
    logic [DEPTH-1:0]                  w_lt;
    logic [PADW-1:0]                   w_eq_pad;

    // scan and probe helpers
    logic                              w_accept;
    logic                              w_oload;
    logic                              w_full;
    logic                              w_pos_ok;
    logic [31:0]                       w_base;
    logic [ate_pkg::SCAN_W-1:0]        w_bits;
    logic [ate_pkg::SCAN_W-1:0]        w_chunk_hit;
    logic                              w_hit_any;
    logic [ate_pkg::SCAN_LG-1:0]       w_hit_off;
    logic                              w_scan_last;
    logic [CW:0]                       w_sum;
    logic [CW-1:0]                     w_mid;

    assign w_accept = i_cmd.valid && i_cmd.ready;
    assign i_cmd.ready = (r_state == S_IDLE);
    assign w_full   = (r_count == CW'(DEPTH));
    assign w_pos_ok = (32'(i_cmd.position) < 32'(r_count));

    // row of cells, each neighbor-linked
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [ate_pkg::DATA_W-1:0] w_prev;
        logic signed [ate_pkg::DATA_W-1:0] w_next;
        if (g == 0) begin : g_first
            assign w_prev = w_data[g];
        end else begin : g_mid_prev
            assign w_prev = w_data[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign w_next = w_data[g];
        end else begin : g_mid_next
            assign w_next = w_data[g+1];
        end
        ate_cell #(
            .IDX (g),
            .CW  (CW)
        ) u_cell (
            .i_clk  (i_clk),
            .i_cmd  (w_ccmd),
            .i_pos  (w_pos),
            .i_prev (w_prev),
            .i_next (w_next),
            .o_data (w_data[g]),
            .o_eq   (w_eq[g]),
            .o_lt   (w_lt[g])
        );
    end

    assign w_eq_pad = PADW'(w_eq);

    // first-match scan over one chunk of compare bits
    always_comb begin
        w_base      = 32'(r_chunk) << ate_pkg::SCAN_LG;
        w_bits      = w_eq_pad[{r_chunk, {ate_pkg::SCAN_LG{1'b0}}} +: ate_pkg::SCAN_W];
        w_hit_any   = 1'b0;
        w_hit_off   = '0;
        for (int k = 0; k < ate_pkg::SCAN_W; k++) begin
            w_chunk_hit[k] = w_bits[k] && ((w_base + 32'(k)) < 32'(r_count));
        end
        for (int k = ate_pkg::SCAN_W - 1; k >= 0; k--) begin
            if (w_chunk_hit[k]) begin
                w_hit_any = 1'b1;
                w_hit_off = ate_pkg::SCAN_LG'(k);
            end
        end
        w_scan_last = ((w_base + 32'(ate_pkg::SCAN_W)) >= 32'(r_count));
    end

    // binary search midpoint, hp is one past the high bound
    assign w_sum = {1'b0, r_lo} + {1'b0, r_hp} - (CW+1)'(1);
    assign w_mid = w_sum[CW:1];

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_key    = r_key;
        n_chunk  = r_chunk;
        n_lo     = r_lo;
        n_hp     = r_hp;
        n_round  = r_round;
        n_rstat  = r_rstat;
        n_rfound = r_rfound;
        n_ridx   = r_ridx;
        w_oload  = 1'b0;
        w_pos    = r_count;
        w_ccmd.mode   = ate_pkg::CM_HOLD;
        w_ccmd.parity = r_round[0];
        w_ccmd.key    = (r_state == S_IDLE) ? i_cmd.value : r_key;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_key    = i_cmd.value;
                    n_rstat  = ate_pkg::ST_OK;
                    n_rfound = 1'b0;
                    n_ridx   = '0;
                    n_chunk  = '0;
                    n_lo     = '0;
                    n_hp     = r_count;
                    n_round  = '0;
                    n_state  = S_OUT;
                    unique case (i_cmd.action)
                        ate_pkg::ACT_APPEND: begin
                            if (w_full) begin
                                n_rstat = ate_pkg::ST_FULL;
                            end else begin
                                w_ccmd.mode = ate_pkg::CM_LOAD;
                                n_count     = r_count + CW'(1);
                            end
                        end
                        ate_pkg::ACT_REMOVE: begin
                            if (w_pos_ok) begin
                                w_ccmd.mode = ate_pkg::CM_SHIFT;
                                w_pos       = CW'(i_cmd.position);
                                n_count     = r_count - CW'(1);
                            end else begin
                                n_rstat = ate_pkg::ST_RANGE;
                            end
                        end
                        ate_pkg::ACT_CLEAR: begin
                            n_count = '0;
                        end
                        ate_pkg::ACT_FIND: begin
                            if (r_count != '0) n_state = S_FIND;
                        end
                        ate_pkg::ACT_BSEARCH: begin
                            if (r_count != '0) n_state = S_BSRCH;
                        end
                        ate_pkg::ACT_REVERSE: begin
                            if (r_count > CW'(1)) n_state = S_REV;
                        end
                        default: n_state = S_OUT;
                    endcase
                end
            end
            S_FIND: begin
                if (w_hit_any) begin
                    n_rfound = 1'b1;
                    n_ridx   = ate_pkg::FIDX_W'(w_base + 32'(w_hit_off));
                    n_state  = S_OUT;
                end else if (w_scan_last) begin
                    n_state = S_OUT;
                end else begin
                    n_chunk = r_chunk + CHW'(1);
                end
            end
            S_BSRCH: begin
                if (r_lo >= r_hp) begin
                    n_state = S_OUT;
                end else if (w_eq[w_mid[IW-1:0]]) begin
                    n_rfound = 1'b1;
                    n_state  = S_OUT;
                end else if (w_lt[w_mid[IW-1:0]]) begin
                    n_hp = w_mid;
                end else begin
                    n_lo = w_mid + CW'(1);
                end
            end
            S_REV: begin
                w_ccmd.mode = ate_pkg::CM_SWAP;
                n_round     = r_round + CW'(1);
                if (r_round == r_count - CW'(1)) n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_ovalid || o_res.ready) begin
                    w_oload = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // result valid
    always_comb begin
        n_ovalid = r_ovalid;
        if (r_ovalid && o_res.ready) n_ovalid = 1'b0;
        if (w_oload) n_ovalid = 1'b1;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
        end
    end

    // work registers
    always_ff @(posedge i_clk) begin
        r_key    <= n_key;
        r_chunk  <= n_chunk;
        r_lo     <= n_lo;
        r_hp     <= n_hp;
        r_round  <= n_round;
        r_rstat  <= n_rstat;
        r_rfound <= n_rfound;
        r_ridx   <= n_ridx;
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (w_oload) begin
            r_ostat  <= r_rstat;
            r_ofound <= r_rfound;
            r_oidx   <= r_ridx;
            r_ofill  <= ate_pkg::FILL_W'(r_count);
        end
    end

    assign o_res.valid       = r_ovalid;
    assign o_res.status      = r_ostat;
    assign o_res.found       = r_ofound;
    assign o_res.found_index = r_oidx;
    assign o_res.fill_count  = r_ofill;

`ifndef ASSERT_OFF
    // fill count stays within the row
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("fill count above depth");

    // a hit is only reported on a non-empty store
    a_found_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_ofound) |-> (r_ofill != '0))
        else $error("found reported on empty store");

    // the fill count moves only on an accepted item
    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_accept |=> $stable(r_count))
        else $error("fill count changed without an item");
`endif

endmodule

### tb/testbench.sv
// self-checking testbench for the array table engine: directed and random command traffic
`timescale 1ns / 100ps

module testbench;

    localparam int STORE_DEPTH = 64;

    // spare command codes, no effect on the store
    localparam logic [ate_pkg::ACT_W-1:0] ACT_SPARE6 = 3'd6;
    localparam logic [ate_pkg::ACT_W-1:0] ACT_SPARE7 = 3'd7;

    // one result item
    typedef struct packed {
        logic [ate_pkg::STAT_W-1:0] status;
        logic                       found;
        logic [ate_pkg::FIDX_W-1:0] found_index;
        logic [ate_pkg::FILL_W-1:0] fill_count;
    } t_outcome;

    logic i_clk;
    logic i_rst_n;

    ate_cmd_if cmd_if ();
    ate_res_if res_if ();

    array_table_engine #(
        .DEPTH(STORE_DEPTH)
    ) u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (cmd_if),
        .o_res  (res_if)
    );

    // shadow copy of the store
    logic signed [ate_pkg::DATA_W-1:0] word_store [STORE_DEPTH];
    int                                word_count = 0;

    t_outcome pending_results[$];
    int       fail_count    = 0;
    int       sent_items    = 0;
    int       send_idle_pct = 0;
    int       recv_idle_pct = 0;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // expected outcome of one command, updates the shadow store
    function automatic t_outcome apply_command(logic [ate_pkg::ACT_W-1:0] act,
                                               logic signed [ate_pkg::DATA_W-1:0] val,
                                               logic [ate_pkg::POS_W-1:0] pos);
        t_outcome                          res;
        int                                lo;
        int                                hi;
        int                                mid;
        logic signed [ate_pkg::DATA_W-1:0] tmp;
        res = '0;
        case (act)
            ate_pkg::ACT_APPEND: begin
                if (word_count < STORE_DEPTH) begin
                    word_store[word_count] = val;
                    word_count++;
                end else begin
                    res.status = ate_pkg::ST_FULL;
                end
            end
            ate_pkg::ACT_REMOVE: begin
                if (int'(pos) < word_count) begin
                    for (int i = int'(pos) + 1; i < word_count; i++)
                        word_store[i-1] = word_store[i];
                    word_count--;
                end else begin
                    res.status = ate_pkg::ST_RANGE;
                end
            end
            ate_pkg::ACT_CLEAR: begin
                word_count = 0;
            end
            ate_pkg::ACT_FIND: begin
                for (int i = 0; i < word_count; i++) begin
                    if (!res.found && word_store[i] == val) begin
                        res.found       = 1'b1;
                        res.found_index = ate_pkg::FIDX_W'(i);
                    end
                end
            end
            ate_pkg::ACT_BSEARCH: begin
                // probe order of a plain binary search, sorted or not
                lo = 0;
                hi = word_count - 1;
                while (lo <= hi && !res.found) begin
                    mid = (lo + hi) / 2;
                    if (val < word_store[mid])
                        hi = mid - 1;
                    else if (val > word_store[mid])
                        lo = mid + 1;
                    else
                        res.found = 1'b1;
                end
            end
            ate_pkg::ACT_REVERSE: begin
                for (int i = 0; i < word_count / 2; i++) begin
                    tmp                          = word_store[i];
                    word_store[i]                = word_store[word_count-1-i];
                    word_store[word_count-1-i]   = tmp;
                end
            end
            default: begin
            end
        endcase
        res.fill_count = ate_pkg::FILL_W'(word_count);
        return res;
    endfunction

    // random word biased toward extremes and small values
    function automatic logic signed [ate_pkg::DATA_W-1:0] rand_word();
        int sel;
        int near_zero;
        sel = $urandom_range(9);
        near_zero = int'($urandom_range(16)) - 8;
        case (sel)
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2, 3, 4: return near_zero;
            default: return $urandom();
        endcase
    endfunction

    // word taken from the store most of the time
    function automatic logic signed [ate_pkg::DATA_W-1:0] pick_member();
        if (word_count > 0 && $urandom_range(99) < 60)
            return word_store[$urandom_range(word_count - 1)];
        return rand_word();
    endfunction

    function automatic logic [ate_pkg::POS_W-1:0] rand_pos();
        return ate_pkg::POS_W'($urandom_range(STORE_DEPTH - 1));
    endfunction

    // send one command item, record its outcome when accepted
    task automatic send_cmd(logic [ate_pkg::ACT_W-1:0] act,
                            logic signed [ate_pkg::DATA_W-1:0] val,
                            logic [ate_pkg::POS_W-1:0] pos);
        if ($urandom_range(99) < send_idle_pct) begin
            cmd_if.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        cmd_if.valid    <= 1'b1;
        cmd_if.action   <= act;
        cmd_if.value    <= val;
        cmd_if.position <= pos;
        @(posedge i_clk);
        while (!cmd_if.ready) @(posedge i_clk);
        pending_results.push_back(apply_command(act, val, pos));
        sent_items++;
    endtask

    // hold the command side until every outcome has come back
    task automatic hold_for_drain();
        cmd_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    function automatic void check_field(string name, int exp_val, int act_val);
        if (exp_val != act_val) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name,
                     exp_val, act_val);
            fail_count++;
        end
    endfunction

    // result check and receiver stalls
    always @(posedge i_clk) begin
        t_outcome exp_res;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result item with no command outstanding", $time);
                fail_count++;
            end else begin
                exp_res = pending_results.pop_front();
                check_field("status", exp_res.status, res_if.status);
                check_field("found", exp_res.found, res_if.found);
                check_field("found_index", exp_res.found_index, res_if.found_index);
                check_field("fill_count", exp_res.fill_count, res_if.fill_count);
            end
        end
        res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // searches, reverse, clear and remove on an empty store
    task automatic test_empty_store();
        send_cmd(ate_pkg::ACT_FIND, 32'sd0, 6'd0);
        send_cmd(ate_pkg::ACT_BSEARCH, 32'sd0, 6'd0);
        send_cmd(ate_pkg::ACT_REVERSE, rand_word(), rand_pos());
        send_cmd(ate_pkg::ACT_CLEAR, rand_word(), rand_pos());
        send_cmd(ate_pkg::ACT_REMOVE, rand_word(), 6'd0);
    endtask

    // extreme words, appended in ascending order
    task automatic test_append_extremes();
        send_cmd(ate_pkg::ACT_APPEND, 32'sh8000_0000, 6'd0);
        send_cmd(ate_pkg::ACT_APPEND, -32'sd1, 6'h3f);
        send_cmd(ate_pkg::ACT_APPEND, 32'sd0, 6'd0);
        send_cmd(ate_pkg::ACT_APPEND, 32'sh7fff_ffff, 6'h3f);
    endtask

    // binary search and find on the sorted store, match at index zero too
    task automatic test_search_sorted();
        send_cmd(ate_pkg::ACT_BSEARCH, 32'sh7fff_ffff, 6'd0);
        send_cmd(ate_pkg::ACT_BSEARCH, 32'sh8000_0000, 6'd0);
        send_cmd(ate_pkg::ACT_BSEARCH, 32'sd1, 6'd0);
        send_cmd(ate_pkg::ACT_FIND, 32'sd0, 6'd0);
        send_cmd(ate_pkg::ACT_FIND, 32'sh8000_0000, 6'd0);
    endtask

    // remove out of range, then reverse and search the unsorted store, then remove in range
    task automatic test_remove_reverse();
        send_cmd(ate_pkg::ACT_REMOVE, rand_word(), 6'd4);
        send_cmd(ate_pkg::ACT_REMOVE, rand_word(), 6'h3f);
        send_cmd(ate_pkg::ACT_REVERSE, rand_word(), rand_pos());
        send_cmd(ate_pkg::ACT_FIND, 32'sh8000_0000, 6'd0);
        send_cmd(ate_pkg::ACT_BSEARCH, 32'sd0, 6'd0);
        send_cmd(ate_pkg::ACT_REMOVE, rand_word(), 6'd3);
        send_cmd(ate_pkg::ACT_REMOVE, rand_word(), 6'd0);
    endtask

    // spare codes leave the store alone, then append, reverse and clear
    task automatic test_spare_codes();
        send_cmd(ACT_SPARE6, rand_word(), 6'h3f);
        send_cmd(ACT_SPARE7, rand_word(), 6'd0);
        send_cmd(ate_pkg::ACT_APPEND, 32'sd5, 6'd0);
        send_cmd(ate_pkg::ACT_REVERSE, rand_word(), rand_pos());
        send_cmd(ate_pkg::ACT_CLEAR, rand_word(), rand_pos());
    endtask

    // fill to capacity, overflow, then work on the full store
    task automatic test_store_full();
        send_cmd(ate_pkg::ACT_CLEAR, rand_word(), rand_pos());
        while (word_count < STORE_DEPTH)
            send_cmd(ate_pkg::ACT_APPEND, rand_word(), rand_pos());
        repeat (2) send_cmd(ate_pkg::ACT_APPEND, rand_word(), rand_pos());
        send_cmd(ate_pkg::ACT_FIND, pick_member(), rand_pos());
        send_cmd(ate_pkg::ACT_REVERSE, rand_word(), rand_pos());
        send_cmd(ate_pkg::ACT_REMOVE, rand_word(), 6'h3f);
        send_cmd(ate_pkg::ACT_APPEND, rand_word(), rand_pos());
    endtask

    // sorted store of random contents, then searches into it
    task automatic build_sorted(int len);
        longint cur;
        cur = -64'sd2147483648 + longint'($urandom_range(32'h7fff_ffff));
        send_cmd(ate_pkg::ACT_CLEAR, rand_word(), rand_pos());
        for (int n = 0; n < len; n++) begin
            send_cmd(ate_pkg::ACT_APPEND, $signed(cur[31:0]), rand_pos());
            cur += longint'($urandom_range(32'h00ff_ffff));
        end
        repeat (len / 2 + 2) begin
            if ($urandom_range(99) < 70)
                send_cmd(ate_pkg::ACT_BSEARCH, pick_member(), rand_pos());
            else
                send_cmd(ate_pkg::ACT_FIND, pick_member(), rand_pos());
        end
    endtask

    // one command of random kind and content
    task automatic random_command();
        int                         sel;
        logic [ate_pkg::POS_W-1:0]  pos;
        sel = $urandom_range(99);
        pos = rand_pos();
        if (sel < 35) begin
            send_cmd(ate_pkg::ACT_APPEND, rand_word(), pos);
        end else if (sel < 50) begin
            if (word_count > 0 && $urandom_range(99) < 70)
                pos = ate_pkg::POS_W'($urandom_range(word_count - 1));
            send_cmd(ate_pkg::ACT_REMOVE, rand_word(), pos);
        end else if (sel < 63) begin
            send_cmd(ate_pkg::ACT_FIND, pick_member(), pos);
        end else if (sel < 75) begin
            send_cmd(ate_pkg::ACT_BSEARCH, pick_member(), pos);
        end else if (sel < 85) begin
            send_cmd(ate_pkg::ACT_REVERSE, rand_word(), pos);
        end else if (sel < 90) begin
            send_cmd(ate_pkg::ACT_CLEAR, rand_word(), pos);
        end else if (sel < 95) begin
            send_cmd(ACT_SPARE6, rand_word(), pos);
        end else begin
            send_cmd(ACT_SPARE7, rand_word(), pos);
        end
    endtask

    // random traffic under one idling setting
    task automatic test_random_traffic(int send_pct, int recv_pct, int n_items,
                                       bit hold_once);
        int start_items;
        bit held;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        start_items   = sent_items;
        held          = 1'b0;
        test_store_full();
        while (sent_items - start_items < n_items) begin
            if ($urandom_range(99) < 12) begin
                if ($urandom_range(99) < 80)
                    build_sorted($urandom_range(1, 12));
                else
                    build_sorted($urandom_range(13, STORE_DEPTH));
            end else begin
                repeat ($urandom_range(8, 16)) random_command();
            end
            if (hold_once && !held) begin
                hold_for_drain();
                held = 1'b1;
            end
        end
    endtask

    // test sequence
    initial begin
        cmd_if.valid    <= 1'b0;
        cmd_if.action   <= ate_pkg::ACT_APPEND;
        cmd_if.value    <= '0;
        cmd_if.position <= '0;
        i_rst_n         <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 23;
        recv_idle_pct = 62;
        test_empty_store();
        test_append_extremes();
        test_search_sorted();
        test_remove_reverse();
        test_spare_codes();

        test_random_traffic(23, 62, 200, 1'b1);
        test_random_traffic(62, 23, 200, 1'b0);
        test_random_traffic(0, 0, 200, 1'b0);

        // drain and watch for stray results
        hold_for_drain();
        repeat (100) @(posedge i_clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

### filelist.f
hdl/ate_pkg.sv
hdl/ate_if.sv
hdl/ate_cell.sv
hdl/array_table_engine.sv
tb/testbench.sv
